>>> sv/kwm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the word matcher.
// Used by kwm_cell, kwm_cell_row and kmp_word_match; depends on nothing.
package kwm_pkg;

  localparam int PAT_MAX        = 16;
  localparam int LEN_W          = 5;
  localparam int BYTE_W         = 8;
  localparam int BYTES_PER_WORD = 8;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 64;
  localparam int COL_W          = 12;
  localparam int LINE_W         = 24;
  localparam int OUT_DATA_W     = 40;

  localparam logic [COL_W-1:0]  COL_MAX    = {COL_W{1'b1}};
  localparam logic [LINE_W-1:0] LINE_MAX   = {LINE_W{1'b1}};
  localparam logic [BYTE_W-1:0] SPACE_CHAR = 8'h20;

  localparam logic CMD_TEXT = 1'b0;
  localparam logic CMD_EOL  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LO = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_HI = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEN    = 2'd2;

  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [BYTE_W-1:0] byte_t;

  // per-cycle control broadcast along the cell row
  typedef struct packed {
    logic  clear;
    logic  step;
    byte_t text_byte;
  } kwm_ctl_t;

  // pattern write broadcast along the cell row
  typedef struct packed {
    logic                  lo_we;
    logic                  hi_we;
    logic [CFG_DATA_W-1:0] data;
  } kwm_cfg_t;

endpackage

>>> sv/kwm_cell.sv
`timescale 1ns / 1ps
// One matcher cell: holds one pattern byte and the flag that the pattern
// prefix ending at this byte matches the text so far. Uses kwm_pkg.
module kwm_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  kwm_pkg::kwm_ctl_t ctl,
  input  logic              pat_we,
  input  kwm_pkg::byte_t    pat_wdata,
  input  logic              enable,
  input  logic              act_in,
  output logic              act_out
);
  import kwm_pkg::*;

  byte_t pat_r, pat_nxt;
  logic  act_r, act_nxt;

  always_comb begin
    pat_nxt = pat_we ? pat_wdata : pat_r;
    priority if (ctl.clear) begin
      act_nxt = 1'b0;
    end else if (ctl.step) begin
      act_nxt = act_in & enable & (pat_r == ctl.text_byte);
    end else begin
      act_nxt = act_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r <= '0;
      act_r <= 1'b0;
    end else begin
      pat_r <= pat_nxt;
      act_r <= act_nxt;
    end
  end

  assign act_out = act_r;

endmodule

>>> sv/kwm_cell_row.sv
`timescale 1ns / 1ps
// Row of kwm_cell instances; each cell takes its left neighbor's match flag.
// Picks the full-match flag at the configured length. Uses kwm_pkg.
module kwm_cell_row (
  input  logic              clk,
  input  logic              rst_n,
  input  kwm_pkg::kwm_ctl_t ctl,
  input  kwm_pkg::kwm_cfg_t cfg,
  input  kwm_pkg::len_t     len,
  output logic              full
);
  import kwm_pkg::*;

  logic [PAT_MAX-1:0] act;
  logic [PAT_MAX-1:0] last_hit;

  for (genvar i = 0; i < PAT_MAX; i++) begin : g_cell
    logic  link_in;
    logic  we;
    byte_t wdata;

    if (i == 0) begin : g_head
      assign link_in = 1'b1;
    end else begin : g_body
      assign link_in = act[i-1];
    end

    if (i < BYTES_PER_WORD) begin : g_lo
      assign we = cfg.lo_we;
    end else begin : g_hi
      assign we = cfg.hi_we;
    end

    assign wdata = cfg.data[BYTE_W*(i % BYTES_PER_WORD) +: BYTE_W];

    kwm_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .pat_we    (we),
      .pat_wdata (wdata),
      .enable    (len > LEN_W'(i)),
      .act_in    (link_in),
      .act_out   (act[i])
    );

    assign last_hit[i] = act[i] & (len == LEN_W'(i + 1));
  end

  assign full = |last_hit;

endmodule

>>> sv/kmp_word_match.sv
`timescale 1ns / 1ps
// Top level of the streaming word matcher: channels, line and column
// counters, result register. Uses kwm_pkg and kwm_cell_row.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------
//  in      | in  | in_tvalid/tready   | tuser: cmd; tdata: text_byte
//  out     | out | out_tvalid/tready  | tdata: line_number, match_start
//  cfg     | in  | cfg_valid/ready    | cfg_index, cfg_data
//
// One input item per cycle while in_tready is high; the match flags advance one cell per byte.
// A result appears on out in the cycle after the space byte that ends it.
// in_tready drops only while a result is held and out_tready is low.
// Synchronous reset clears pattern, flags and column, sets line and length to 1; cfg_ready is always 1.
module kmp_word_match (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [kwm_pkg::BYTE_W-1:0]          in_tdata,   // [7:0] text_byte
  input  logic                                in_tuser,   // [0] cmd
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [kwm_pkg::OUT_DATA_W-1:0]      out_tdata,  // [23:0] line_number,
                                                          // [35:24] match_start
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [kwm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [kwm_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import kwm_pkg::*;

  logic              in_fire, cfg_fire, cfg_hit, eol_fire, text_fire;
  logic              match_full, res_load;
  kwm_ctl_t          ctl;
  kwm_cfg_t          pcfg;
  len_t              len_r, len_nxt;
  logic [LEN_W-1:0]  len_raw;
  logic [COL_W-1:0]  col_r, col_nxt, start_col;
  logic [LINE_W-1:0] line_r, line_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [LINE_W-1:0] out_line_r, out_line_nxt;
  logic [COL_W-1:0]  out_start_r, out_start_nxt;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid & cfg_ready;
  assign cfg_hit   = cfg_fire & ((cfg_index == CFG_PAT_LO) || (cfg_index == CFG_PAT_HI) ||
                                 (cfg_index == CFG_LEN));

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid & in_tready;
  assign eol_fire  = in_fire & (in_tuser == CMD_EOL);
  assign text_fire = in_fire & (in_tuser == CMD_TEXT);

  assign ctl.clear     = cfg_hit | eol_fire;
  assign ctl.step      = text_fire;
  assign ctl.text_byte = in_tdata;

  assign pcfg.lo_we = cfg_fire & (cfg_index == CFG_PAT_LO);
  assign pcfg.hi_we = cfg_fire & (cfg_index == CFG_PAT_HI);
  assign pcfg.data  = cfg_data;

  kwm_cell_row u_row (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .cfg   (pcfg),
    .len   (len_r),
    .full  (match_full)
  );

  // clamp the written length to 1..PAT_MAX
  assign len_raw = cfg_data[LEN_W-1:0];
  always_comb begin
    len_nxt = len_r;
    if (cfg_fire && (cfg_index == CFG_PAT_LO || cfg_index == CFG_PAT_HI) == 1'b0 &&
        cfg_index == CFG_LEN) begin
      priority if (len_raw == '0) begin
        len_nxt = LEN_W'(1);
      end else if (len_raw > LEN_W'(PAT_MAX)) begin
        len_nxt = LEN_W'(PAT_MAX);
      end else begin
        len_nxt = len_raw;
      end
    end
  end

  assign start_col = (col_r >= {{(COL_W-LEN_W){1'b0}}, len_r}) ?
                     col_r - {{(COL_W-LEN_W){1'b0}}, len_r} : '0;
  assign res_load  = text_fire & match_full & (in_tdata == SPACE_CHAR);

  always_comb begin
    col_nxt  = col_r;
    line_nxt = line_r;
    priority if (eol_fire) begin
      col_nxt = '0;
      if (line_r != LINE_MAX) begin
        line_nxt = line_r + LINE_W'(1);
      end
    end else if (text_fire) begin
      if (col_r != COL_MAX) begin
        col_nxt = col_r + COL_W'(1);
      end
    end else begin
      col_nxt = col_r;
    end
  end

  always_comb begin
    out_line_nxt  = out_line_r;
    out_start_nxt = out_start_r;
    priority if (res_load) begin
      out_valid_nxt = 1'b1;
      out_line_nxt  = line_r;
      out_start_nxt = start_col;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= LEN_W'(1);
      col_r       <= '0;
      line_r      <= LINE_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      col_r       <= col_nxt;
      line_r      <= line_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_line_r  <= out_line_nxt;
    out_start_r <= out_start_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-COL_W-LINE_W){1'b0}}, out_start_r, out_line_r};

  a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_hit |=> !match_full)
    else $error("match flags survive a pattern write");

  a_eol_clears: assert property (@(posedge clk) disable iff (!rst_n)
    eol_fire |=> (col_r == '0) && !match_full)
    else $error("end of line left column or match progress");

  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    line_r != '0)
    else $error("line counter wrapped to zero");

  a_col_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    text_fire && (col_r == COL_MAX) |=> col_r == COL_MAX)
    else $error("column counter wrapped");

  a_start_in_line: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |=> out_tvalid && (out_start_r <= $past(col_r)))
    else $error("match start beyond current column");

endmodule
